// ===== src/lst_pkg.sv =====
// Shared types, constants and helper functions of the token scanner.
// No dependencies; used by every other file in src.
package lst_pkg;

    // Default sizes handed to the top level
    localparam int KEYWORD_BYTES_DEF = 8;
    localparam int LINE_BITS_DEF     = 20;
    localparam int MAX_RES           = 4;
    localparam int ID_LEN_TOP        = 15;
    localparam int ESC_LIMIT         = 255;

    // Token kinds
    localparam logic [5:0] K_ID       = 6'd0;
    localparam logic [5:0] K_NUMBER   = 6'd1;
    localparam logic [5:0] K_STRING   = 6'd2;
    localparam logic [5:0] K_BOOL     = 6'd3;
    localparam logic [5:0] K_NIL      = 6'd4;
    localparam logic [5:0] K_DO       = 6'd5;
    localparam logic [5:0] K_ELSE     = 6'd6;
    localparam logic [5:0] K_END      = 6'd7;
    localparam logic [5:0] K_FUNCTION = 6'd8;
    localparam logic [5:0] K_IF       = 6'd9;
    localparam logic [5:0] K_LOCAL    = 6'd10;
    localparam logic [5:0] K_READ     = 6'd11;
    localparam logic [5:0] K_RETURN   = 6'd12;
    localparam logic [5:0] K_THEN     = 6'd13;
    localparam logic [5:0] K_WHILE    = 6'd14;
    localparam logic [5:0] K_WRITE    = 6'd15;
    localparam logic [5:0] K_RESERVED = 6'd16;
    localparam logic [5:0] K_PLUS     = 6'd17;
    localparam logic [5:0] K_MINUS    = 6'd18;
    localparam logic [5:0] K_MUL      = 6'd19;
    localparam logic [5:0] K_DIV      = 6'd20;
    localparam logic [5:0] K_POW      = 6'd21;
    localparam logic [5:0] K_MOD      = 6'd22;
    localparam logic [5:0] K_CONC     = 6'd23;
    localparam logic [5:0] K_EQ       = 6'd24;
    localparam logic [5:0] K_NE       = 6'd25;
    localparam logic [5:0] K_LT       = 6'd26;
    localparam logic [5:0] K_LE       = 6'd27;
    localparam logic [5:0] K_GT       = 6'd28;
    localparam logic [5:0] K_GE       = 6'd29;
    localparam logic [5:0] K_ASSIGN   = 6'd30;
    localparam logic [5:0] K_LPAREN   = 6'd31;
    localparam logic [5:0] K_RPAREN   = 6'd32;
    localparam logic [5:0] K_SEMI     = 6'd33;
    localparam logic [5:0] K_COMMA    = 6'd34;
    localparam logic [5:0] K_EOF      = 6'd35;

    // Number part codes
    localparam logic [1:0] NP_INT  = 2'd0;
    localparam logic [1:0] NP_FRAC = 2'd1;
    localparam logic [1:0] NP_EXP  = 2'd2;

    // Result kinds
    localparam logic RK_ATTR = 1'b0;
    localparam logic RK_END  = 1'b1;

    // Scanner modes, one-hot
    typedef enum logic [20:0] {
        M_START     = 21'h000001,
        M_ID        = 21'h000002,
        M_NUM       = 21'h000004,
        M_AFTER_DOT = 21'h000008,
        M_AFTER_E   = 21'h000010,
        M_AFTER_SGN = 21'h000020,
        M_ZERO      = 21'h000040,
        M_STR       = 21'h000080,
        M_ESC       = 21'h000100,
        M_DEC       = 21'h000200,
        M_MINUS     = 21'h000400,
        M_COM1      = 21'h000800,
        M_COM2      = 21'h001000,
        M_LINE      = 21'h002000,
        M_BLOCK     = 21'h004000,
        M_BLOCK_BR  = 21'h008000,
        M_TILDE     = 21'h010000,
        M_LESS      = 21'h020000,
        M_GREATER   = 21'h040000,
        M_EQUAL     = 21'h080000,
        M_DOT       = 21'h100000
    } mode_t;

    // One result entry; the line travels per request
    typedef struct packed {
        logic       rk;
        logic [7:0] attr;
        logic [5:0] tk;
        logic       err;
    } res_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic res_t attr_r(input logic [7:0] b);
        res_t r;
        r.rk   = RK_ATTR;
        r.attr = b;
        r.tk   = K_ID;
        r.err  = 1'b0;
        return r;
    endfunction

    function automatic res_t end_r(input logic [5:0] k, input logic e);
        res_t r;
        r.rk   = RK_END;
        r.attr = 8'd0;
        r.tk   = k;
        r.err  = e;
        return r;
    endfunction

    // Keyword lookup; pk holds the first identifier byte in its top byte
    function automatic logic [5:0] classify(input logic [63:0] pk, input logic [3:0] len);
        logic [5:0] k;
        k = K_ID;
        case (len)
            4'd2:
            begin
                if (pk[63:48] == "do") k = K_DO;
                else if (pk[63:48] == "if") k = K_IF;
                else if (pk[63:48] == "in" || pk[63:48] == "or") k = K_RESERVED;
            end
            4'd3:
            begin
                if (pk[63:40] == "end") k = K_END;
                else if (pk[63:40] == "nil") k = K_NIL;
                else if (pk[63:40] == "and" || pk[63:40] == "for" || pk[63:40] == "not")
                    k = K_RESERVED;
            end
            4'd4:
            begin
                if (pk[63:32] == "else") k = K_ELSE;
                else if (pk[63:32] == "read") k = K_READ;
                else if (pk[63:32] == "then") k = K_THEN;
                else if (pk[63:32] == "true") k = K_BOOL;
            end
            4'd5:
            begin
                if (pk[63:24] == "false") k = K_BOOL;
                else if (pk[63:24] == "local") k = K_LOCAL;
                else if (pk[63:24] == "while") k = K_WHILE;
                else if (pk[63:24] == "write") k = K_WRITE;
                else if (pk[63:24] == "break" || pk[63:24] == "until") k = K_RESERVED;
            end
            4'd6:
            begin
                if (pk[63:16] == "return") k = K_RETURN;
                else if (pk[63:16] == "elseif" || pk[63:16] == "repeat") k = K_RESERVED;
            end
            4'd8:
            begin
                if (pk == "function") k = K_FUNCTION;
            end
            default: k = K_ID;
        endcase
        return k;
    endfunction

endpackage

// ===== src/lst_pass.sv =====
// One scan of one character from a given scanner state.
// Depends on lst_pkg.
module lst_pass #(
    parameter int KEYWORD_BYTES = lst_pkg::KEYWORD_BYTES_DEF
) (
    input  lst_pkg::mode_t            mode_in,
    input  logic [1:0]                np_in,
    input  logic [9:0]                ev_in,
    input  logic [1:0]                ec_in,
    input  logic [KEYWORD_BYTES*8-1:0] pf_in,
    input  logic [3:0]                il_in,
    input  logic [7:0]                c,
    input  logic                      eof,
    output lst_pkg::mode_t            mode_out,
    output logic [1:0]                np_out,
    output logic [9:0]                ev_out,
    output logic [1:0]                ec_out,
    output logic [KEYWORD_BYTES*8-1:0] pf_out,
    output logic [3:0]                il_out,
    output logic                      again,
    output logic [1:0]                n,
    output lst_pkg::res_t             r0,
    output lst_pkg::res_t             r1
);

    logic        dig;
    logic        idch;
    logic [63:0] pk;
    logic [9:0]  ev10;
    logic [1:0]  ec1;

    // Character classes and escape arithmetic
    assign dig  = !eof && lst_pkg::is_digit(c);
    assign idch = !eof && (lst_pkg::is_alpha(c) || lst_pkg::is_digit(c) || c == "_");
    assign ev10 = {ev_in[6:0], 3'b000} + {ev_in[8:0], 1'b0} + {6'd0, c[3:0] - 4'd0};
    assign ec1  = ec_in + 2'd1;

    // Keyword prefix with its first byte on top
    always_comb
    begin
        for (int i = 0; i < 8; i++)
            pk[63-8*i -: 8] = pf_in[8*i +: 8];
    end

    // Scan step
    always_comb
    begin
        mode_out = mode_in;
        np_out   = np_in;
        ev_out   = ev_in;
        ec_out   = ec_in;
        pf_out   = pf_in;
        il_out   = il_in;
        again    = 1'b0;
        n        = 2'd0;
        r0       = lst_pkg::attr_r(8'd0);
        r1       = lst_pkg::attr_r(8'd0);
        case (mode_in)
            lst_pkg::M_START:
            begin
                if (eof)
                begin
                    r0 = lst_pkg::end_r(lst_pkg::K_EOF, 1'b0); n = 2'd1;
                end
                else if (lst_pkg::is_space(c))
                begin
                end
                else if (lst_pkg::is_alpha(c) || c == "_")
                begin
                    pf_out[7:0] = c;
                    il_out      = 4'd1;
                    r0 = lst_pkg::attr_r(c); n = 2'd1;
                    mode_out = lst_pkg::M_ID;
                end
                else if (c >= "1" && c <= "9")
                begin
                    r0 = lst_pkg::attr_r(c); n = 2'd1;
                    np_out = lst_pkg::NP_INT;
                    mode_out = lst_pkg::M_NUM;
                end
                else if (c == "0") mode_out = lst_pkg::M_ZERO;
                else if (c == "\"") mode_out = lst_pkg::M_STR;
                else if (c == "-") mode_out = lst_pkg::M_MINUS;
                else if (c == "~") mode_out = lst_pkg::M_TILDE;
                else if (c == "<") mode_out = lst_pkg::M_LESS;
                else if (c == ">") mode_out = lst_pkg::M_GREATER;
                else if (c == "=") mode_out = lst_pkg::M_EQUAL;
                else if (c == ".") mode_out = lst_pkg::M_DOT;
                else
                begin
                    n = 2'd1;
                    if (c == "+") r0 = lst_pkg::end_r(lst_pkg::K_PLUS, 1'b0);
                    else if (c == "*") r0 = lst_pkg::end_r(lst_pkg::K_MUL, 1'b0);
                    else if (c == "/") r0 = lst_pkg::end_r(lst_pkg::K_DIV, 1'b0);
                    else if (c == "^") r0 = lst_pkg::end_r(lst_pkg::K_POW, 1'b0);
                    else if (c == "%") r0 = lst_pkg::end_r(lst_pkg::K_MOD, 1'b0);
                    else if (c == "(") r0 = lst_pkg::end_r(lst_pkg::K_LPAREN, 1'b0);
                    else if (c == ")") r0 = lst_pkg::end_r(lst_pkg::K_RPAREN, 1'b0);
                    else if (c == ";") r0 = lst_pkg::end_r(lst_pkg::K_SEMI, 1'b0);
                    else if (c == ",") r0 = lst_pkg::end_r(lst_pkg::K_COMMA, 1'b0);
                    else r0 = lst_pkg::end_r(lst_pkg::K_ID, 1'b1);
                end
            end
            lst_pkg::M_ID:
            begin
                if (idch)
                begin
                    for (int i = 0; i < KEYWORD_BYTES; i++)
                        if ({1'b0, il_in} == 5'(i))
                            pf_out[8*i +: 8] = c;
                    if (il_in < 4'(lst_pkg::ID_LEN_TOP))
                        il_out = il_in + 4'd1;
                    r0 = lst_pkg::attr_r(c); n = 2'd1;
                end
                else
                begin
                    r0 = lst_pkg::end_r(lst_pkg::classify(pk, il_in), 1'b0); n = 2'd1;
                    mode_out = lst_pkg::M_START; again = 1'b1;
                end
            end
            lst_pkg::M_NUM:
            begin
                if (dig)
                begin
                    r0 = lst_pkg::attr_r(c); n = 2'd1;
                end
                else if (!eof && c == "." && np_in == lst_pkg::NP_INT)
                begin
                    r0 = lst_pkg::attr_r(c); n = 2'd1;
                    np_out = lst_pkg::NP_FRAC; mode_out = lst_pkg::M_AFTER_DOT;
                end
                else if (!eof && (c == "e" || c == "E") && np_in != lst_pkg::NP_EXP)
                begin
                    r0 = lst_pkg::attr_r(c); n = 2'd1;
                    np_out = lst_pkg::NP_EXP; mode_out = lst_pkg::M_AFTER_E;
                end
                else
                begin
                    r0 = lst_pkg::end_r(lst_pkg::K_NUMBER, 1'b0); n = 2'd1;
                    mode_out = lst_pkg::M_START; again = 1'b1;
                end
            end
            lst_pkg::M_AFTER_DOT, lst_pkg::M_AFTER_SGN:
            begin
                if (dig)
                begin
                    r0 = lst_pkg::attr_r(c); n = 2'd1; mode_out = lst_pkg::M_NUM;
                end
                else
                begin
                    r0 = lst_pkg::end_r(lst_pkg::K_NUMBER, 1'b1); n = 2'd1;
                    mode_out = lst_pkg::M_START; again = 1'b1;
                end
            end
            lst_pkg::M_AFTER_E:
            begin
                if (!eof && (c == "+" || c == "-"))
                begin
                    r0 = lst_pkg::attr_r(c); n = 2'd1; mode_out = lst_pkg::M_AFTER_SGN;
                end
                else if (dig)
                begin
                    r0 = lst_pkg::attr_r(c); n = 2'd1; mode_out = lst_pkg::M_NUM;
                end
                else
                begin
                    r0 = lst_pkg::end_r(lst_pkg::K_NUMBER, 1'b1); n = 2'd1;
                    mode_out = lst_pkg::M_START; again = 1'b1;
                end
            end
            lst_pkg::M_ZERO:
            begin
                // leading zeros fold into one
                if (!eof && c == "0")
                begin
                end
                else if (dig)
                begin
                    r0 = lst_pkg::attr_r(c); n = 2'd1;
                    np_out = lst_pkg::NP_INT; mode_out = lst_pkg::M_NUM;
                end
                else if (!eof && c == ".")
                begin
                    r0 = lst_pkg::attr_r("0"); r1 = lst_pkg::attr_r(c); n = 2'd2;
                    np_out = lst_pkg::NP_FRAC; mode_out = lst_pkg::M_AFTER_DOT;
                end
                else if (!eof && (c == "e" || c == "E"))
                begin
                    r0 = lst_pkg::attr_r("0"); r1 = lst_pkg::attr_r(c); n = 2'd2;
                    np_out = lst_pkg::NP_EXP; mode_out = lst_pkg::M_AFTER_E;
                end
                else
                begin
                    r0 = lst_pkg::attr_r("0");
                    r1 = lst_pkg::end_r(lst_pkg::K_NUMBER, 1'b0); n = 2'd2;
                    mode_out = lst_pkg::M_START; again = 1'b1;
                end
            end
            lst_pkg::M_STR:
            begin
                if (eof)
                begin
                    r0 = lst_pkg::end_r(lst_pkg::K_STRING, 1'b1); n = 2'd1;
                    mode_out = lst_pkg::M_START;
                end
                else if (c == "\\") mode_out = lst_pkg::M_ESC;
                else if (c == "\"")
                begin
                    r0 = lst_pkg::end_r(lst_pkg::K_STRING, 1'b0); n = 2'd1;
                    mode_out = lst_pkg::M_START;
                end
                else
                begin
                    r0 = lst_pkg::attr_r(c); n = 2'd1;
                end
            end
            lst_pkg::M_ESC:
            begin
                mode_out = lst_pkg::M_STR;
                if (eof || !(c == "n" || c == "t" || c == "\\" || c == "\"" || dig))
                begin
                    r0 = lst_pkg::end_r(lst_pkg::K_STRING, 1'b1); n = 2'd1;
                    mode_out = lst_pkg::M_START;
                end
                else if (c == "n")
                begin
                    r0 = lst_pkg::attr_r(8'd10); n = 2'd1;
                end
                else if (c == "t")
                begin
                    r0 = lst_pkg::attr_r(8'd9); n = 2'd1;
                end
                else if (dig)
                begin
                    ev_out = {6'd0, c[3:0]};
                    ec_out = 2'd1;
                    mode_out = lst_pkg::M_DEC;
                end
                else
                begin
                    r0 = lst_pkg::attr_r(c); n = 2'd1;
                end
            end
            lst_pkg::M_DEC:
            begin
                if (dig)
                begin
                    ev_out = ev10;
                    ec_out = ec1;
                    if (ec1 == 2'd3 || ec1 == 2'd0)
                    begin
                        n = 2'd1;
                        if (ev10 <= 10'(lst_pkg::ESC_LIMIT))
                        begin
                            r0 = lst_pkg::attr_r(ev10[7:0]); mode_out = lst_pkg::M_STR;
                        end
                        else
                        begin
                            r0 = lst_pkg::end_r(lst_pkg::K_STRING, 1'b1);
                            mode_out = lst_pkg::M_START;
                        end
                    end
                end
                else
                begin
                    // short escape: the character goes back as string text
                    r0 = lst_pkg::attr_r(ev_in[7:0]); n = 2'd1;
                    mode_out = lst_pkg::M_STR; again = 1'b1;
                end
            end
            lst_pkg::M_MINUS:
            begin
                if (!eof && c == "-") mode_out = lst_pkg::M_COM1;
                else
                begin
                    r0 = lst_pkg::end_r(lst_pkg::K_MINUS, 1'b0); n = 2'd1;
                    mode_out = lst_pkg::M_START; again = 1'b1;
                end
            end
            lst_pkg::M_COM1, lst_pkg::M_COM2:
            begin
                if (eof)
                begin
                    r0 = lst_pkg::end_r(lst_pkg::K_EOF, 1'b0); n = 2'd1;
                    mode_out = lst_pkg::M_START;
                end
                else if (c == "[")
                    mode_out = (mode_in == lst_pkg::M_COM1) ? lst_pkg::M_COM2 : lst_pkg::M_BLOCK;
                else if (c == 8'd10) mode_out = lst_pkg::M_START;
                else mode_out = lst_pkg::M_LINE;
            end
            lst_pkg::M_LINE:
            begin
                if (eof)
                begin
                    r0 = lst_pkg::end_r(lst_pkg::K_EOF, 1'b0); n = 2'd1;
                    mode_out = lst_pkg::M_START;
                end
                else if (c == 8'd10) mode_out = lst_pkg::M_START;
            end
            lst_pkg::M_BLOCK, lst_pkg::M_BLOCK_BR:
            begin
                if (eof)
                begin
                    r0 = lst_pkg::end_r(lst_pkg::K_EOF, 1'b1); n = 2'd1;
                    mode_out = lst_pkg::M_START;
                end
                else if (c == "]")
                    mode_out = (mode_in == lst_pkg::M_BLOCK) ? lst_pkg::M_BLOCK_BR
                                                             : lst_pkg::M_START;
                else mode_out = lst_pkg::M_BLOCK;
            end
            lst_pkg::M_TILDE, lst_pkg::M_LESS, lst_pkg::M_GREATER,
            lst_pkg::M_EQUAL, lst_pkg::M_DOT:
            begin
                n = 2'd1;
                mode_out = lst_pkg::M_START;
                if (!eof && ((mode_in == lst_pkg::M_DOT) ? (c == ".") : (c == "=")))
                begin
                    case (mode_in)
                        lst_pkg::M_TILDE:   r0 = lst_pkg::end_r(lst_pkg::K_NE, 1'b0);
                        lst_pkg::M_LESS:    r0 = lst_pkg::end_r(lst_pkg::K_LE, 1'b0);
                        lst_pkg::M_GREATER: r0 = lst_pkg::end_r(lst_pkg::K_GE, 1'b0);
                        lst_pkg::M_EQUAL:   r0 = lst_pkg::end_r(lst_pkg::K_EQ, 1'b0);
                        default:            r0 = lst_pkg::end_r(lst_pkg::K_CONC, 1'b0);
                    endcase
                end
                else
                begin
                    again = 1'b1;
                    case (mode_in)
                        lst_pkg::M_TILDE:   r0 = lst_pkg::end_r(lst_pkg::K_NE, 1'b1);
                        lst_pkg::M_LESS:    r0 = lst_pkg::end_r(lst_pkg::K_LT, 1'b0);
                        lst_pkg::M_GREATER: r0 = lst_pkg::end_r(lst_pkg::K_GT, 1'b0);
                        lst_pkg::M_EQUAL:   r0 = lst_pkg::end_r(lst_pkg::K_ASSIGN, 1'b0);
                        default:            r0 = lst_pkg::end_r(lst_pkg::K_CONC, 1'b1);
                    endcase
                end
            end
            default:
            begin
                mode_out = lst_pkg::M_START;
                again    = 1'b1;
            end
        endcase
    end

endmodule

// ===== src/lst_core.sv =====
// Scanner state registers and the two chained scan passes of one request.
// Depends on lst_pkg and lst_pass.
module lst_core #(
    parameter int KEYWORD_BYTES = lst_pkg::KEYWORD_BYTES_DEF,
    parameter int LINE_BITS     = lst_pkg::LINE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           c,
    input  logic                 eof,
    output lst_pkg::res_t        res [lst_pkg::MAX_RES],
    output logic [2:0]           nres,
    output logic [LINE_BITS-1:0] line_cur
);

    lst_pkg::mode_t             mode_reg, mode_a, mode_b, mode_next;
    logic [1:0]                 np_reg, np_a, np_b, np_next;
    logic [9:0]                 ev_reg, ev_a, ev_b, ev_next;
    logic [1:0]                 ec_reg, ec_a, ec_b, ec_next;
    logic [KEYWORD_BYTES*8-1:0] pf_reg, pf_a, pf_b, pf_next;
    logic [3:0]                 il_reg, il_a, il_b, il_next;
    logic [LINE_BITS-1:0]       line_reg, line_next;
    logic                       again_a, again_b;
    logic [1:0]                 n_a, n_b;
    lst_pkg::res_t              ra0, ra1, rb0, rb1;
    logic [1:0]                 nb;

    // First scan of the character
    lst_pass #(.KEYWORD_BYTES(KEYWORD_BYTES)) u_pass_a (
        .mode_in(mode_reg), .np_in(np_reg), .ev_in(ev_reg), .ec_in(ec_reg),
        .pf_in(pf_reg), .il_in(il_reg), .c(c), .eof(eof),
        .mode_out(mode_a), .np_out(np_a), .ev_out(ev_a), .ec_out(ec_a),
        .pf_out(pf_a), .il_out(il_a), .again(again_a), .n(n_a), .r0(ra0), .r1(ra1)
    );

    // Rescan after a token or a short escape ended on this character
    lst_pass #(.KEYWORD_BYTES(KEYWORD_BYTES)) u_pass_b (
        .mode_in(mode_a), .np_in(np_a), .ev_in(ev_a), .ec_in(ec_a),
        .pf_in(pf_a), .il_in(il_a), .c(c), .eof(eof),
        .mode_out(mode_b), .np_out(np_b), .ev_out(ev_b), .ec_out(ec_b),
        .pf_out(pf_b), .il_out(il_b), .again(again_b), .n(n_b), .r0(rb0), .r1(rb1)
    );

    // Pick final state; again_b never rises since a rescan always consumes
    always_comb
    begin
        if (again_a && !again_b)
        begin
            mode_next = mode_b; np_next = np_b; ev_next = ev_b;
            ec_next = ec_b; pf_next = pf_b; il_next = il_b; nb = n_b;
        end
        else
        begin
            mode_next = mode_a; np_next = np_a; ev_next = ev_a;
            ec_next = ec_a; pf_next = pf_a; il_next = il_a;
            nb = again_a ? n_b : 2'd0;
        end
    end

    // Pack results of both passes in order
    always_comb
    begin
        nres = {1'b0, n_a} + {1'b0, nb};
        res[0] = (n_a != 2'd0) ? ra0 : rb0;
        res[1] = (n_a == 2'd2) ? ra1 : ((n_a == 2'd1) ? rb0 : rb1);
        res[2] = (n_a == 2'd2) ? rb0 : rb1;
        res[3] = rb1;
    end

    // A token end normally carries the line held at the start of the request;
    // a bad escape closes the string after its newline has been counted
    assign line_next = (!eof && c == 8'd10 && line_reg != {LINE_BITS{1'b1}})
                       ? line_reg + 1'b1 : line_reg;
    assign line_cur  = (mode_reg == lst_pkg::M_ESC) ? line_next : line_reg;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= lst_pkg::M_START;
            np_reg   <= lst_pkg::NP_INT;
            ev_reg   <= '0;
            ec_reg   <= '0;
            pf_reg   <= '0;
            il_reg   <= '0;
            line_reg <= LINE_BITS'(1);
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            np_reg   <= np_next;
            ev_reg   <= ev_next;
            ec_reg   <= ec_next;
            pf_reg   <= pf_next;
            il_reg   <= il_next;
            line_reg <= line_next;
        end
    end

endmodule

// ===== src/lst_outq.sv =====
// Result register bank: holds the results of one request and sends them in order.
// Depends on lst_pkg.
module lst_outq #(
    parameter int LINE_BITS = lst_pkg::LINE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  lst_pkg::res_t        res [lst_pkg::MAX_RES],
    input  logic [2:0]           nres,
    input  logic [LINE_BITS-1:0] line_in,
    input  logic                 pop,
    output logic                 busy_next_free,
    output logic                 out_valid,
    output lst_pkg::res_t        head,
    output logic [LINE_BITS-1:0] line_out,
    output logic                 last
);

    lst_pkg::res_t        buf_reg [lst_pkg::MAX_RES];
    logic [2:0]           rem_reg, rem_next;
    logic [1:0]           idx_reg, idx_next;
    logic [LINE_BITS-1:0] line_reg;

    // Room for a new request: empty or the final result leaves now
    assign busy_next_free = (rem_reg == 3'd0) || (rem_reg == 3'd1 && pop);
    assign out_valid      = (rem_reg != 3'd0);
    assign head           = buf_reg[idx_reg];
    assign line_out       = line_reg;
    assign last           = (rem_reg == 3'd1);

    // Count and read pointer
    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (load)
        begin
            rem_next = nres;
            idx_next = 2'd0;
        end
        else if (pop)
        begin
            rem_next = rem_reg - 3'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < lst_pkg::MAX_RES; i++)
                buf_reg[i] <= res[i];
            line_reg <= line_in;
        end
    end

endmodule

// ===== src/lua_subset_token_scanner_top.sv =====
// Top level of the token scanner: input handshake, scan core and result bank.
// Depends on lst_pkg, lst_core and lst_outq.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+----------------------------------------------
//  in      | to block  | in_valid/in_stall | char_byte, end_of_input
//  out     | from block| out_valid/out_stall | result_kind, attr_byte, token_kind,
//          |           |                  | token_line, lex_error, last
//
// A source byte is scanned in the cycle it is taken; its results leave the result
// bank one per cycle while out_stall is low, the first in the cycle after. A request
// giving at most one result sustains one byte per cycle while out_stall is low; more
// results stall the input until the last leaves the bank's single output port.
// Reset puts the scanner in its start state with line 1 and an empty bank.
// A stalled output holds its result and stalls the input while the bank holds any result.
module lua_subset_token_scanner_top #(
    parameter int KEYWORD_BYTES = lst_pkg::KEYWORD_BYTES_DEF,
    parameter int LINE_BITS     = lst_pkg::LINE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           char_byte,
    input  logic                 end_of_input,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 result_kind,
    output logic [7:0]           attr_byte,
    output logic [5:0]           token_kind,
    output logic [LINE_BITS-1:0] token_line,
    output logic                 lex_error,
    output logic                 last
);

    lst_pkg::res_t        res [lst_pkg::MAX_RES];
    lst_pkg::res_t        head;
    logic [2:0]           nres;
    logic [LINE_BITS-1:0] line_cur, line_q;
    logic                 free, take, pop;

    // Handshakes
    assign pop      = out_valid && !out_stall;
    assign in_stall = !free;
    assign take     = in_valid && free;

    lst_core #(.KEYWORD_BYTES(KEYWORD_BYTES), .LINE_BITS(LINE_BITS)) u_core (
        .clk(clk), .rst_n(rst_n), .take(take), .c(char_byte), .eof(end_of_input),
        .res(res), .nres(nres), .line_cur(line_cur)
    );

    lst_outq #(.LINE_BITS(LINE_BITS)) u_outq (
        .clk(clk), .rst_n(rst_n), .load(take), .res(res), .nres(nres),
        .line_in(line_cur), .pop(pop), .busy_next_free(free), .out_valid(out_valid),
        .head(head), .line_out(line_q), .last(last)
    );

    // Output fields; token fields read zero on attribute results
    assign result_kind = head.rk;
    assign attr_byte   = head.attr;
    assign token_kind  = head.tk;
    assign lex_error   = head.err;
    assign token_line  = (head.rk == lst_pkg::RK_END) ? line_q : '0;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for lua_subset_token_scanner_top: a byte-stream driver, an output monitor
// and a scanner predictor that builds the expected attribute and token-end results.
// Depends on lst_pkg (token kinds, mode_t) and the RTL under src.
`timescale 1ns / 100ps

module tb;
    import lst_pkg::*;

    localparam int          LINE_W   = 20;
    localparam logic [19:0] LINE_TOP = 20'hFFFFF;
    localparam int          IDLE_LIM = 5000;

    typedef struct {
        logic [7:0] ch;
        logic       eof;
        bit         hold;  // wait until all expected results are back
    } src_req_t;

    typedef struct {
        logic              rk;
        logic [7:0]        attr;
        logic [5:0]        tk;
        logic [LINE_W-1:0] line;
        logic              err;
        logic              lst;
    } tok_res_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        char_byte = 8'd0;
    logic              end_of_input = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              result_kind;
    logic [7:0]        attr_byte;
    logic [5:0]        token_kind;
    logic [LINE_W-1:0] token_line;
    logic              lex_error;
    logic              last;

    src_req_t src_q[$];
    tok_res_t tok_exp_q[$];
    tok_res_t step_buf[$];
    int       errors = 0;
    int       sent = 0;
    int       idle_cycles = 0;
    bit       took = 1'b0;

    // Scanner state mirror
    mode_t             sc_mode = M_START;
    logic [1:0]        num_part = NP_INT;
    logic [9:0]        esc_val = '0;
    logic [1:0]        esc_cnt = '0;
    logic [7:0]        id_pref[8];
    logic [3:0]        id_len = '0;
    logic [LINE_W-1:0] line_no = LINE_W'(1);
    logic [LINE_W-1:0] line_prev = LINE_W'(1);

    string      kw_txt[23] = '{"do", "else", "end", "false", "function", "if", "local", "nil",
                               "read", "return", "then", "true", "while", "write", "and",
                               "break", "elseif", "for", "in", "not", "or", "repeat", "until"};
    logic [5:0] kw_kind[23] = '{K_DO, K_ELSE, K_END, K_BOOL, K_FUNCTION, K_IF, K_LOCAL, K_NIL,
                                K_READ, K_RETURN, K_THEN, K_BOOL, K_WHILE, K_WRITE, K_RESERVED,
                                K_RESERVED, K_RESERVED, K_RESERVED, K_RESERVED, K_RESERVED,
                                K_RESERVED, K_RESERVED, K_RESERVED};

    lua_subset_token_scanner_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .char_byte(char_byte), .end_of_input(end_of_input),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .attr_byte(attr_byte), .token_kind(token_kind),
        .token_line(token_line), .lex_error(lex_error), .last(last)
    );

    always #1 clk = ~clk;

    // ---------------- predictor ----------------
    function automatic void put_res(logic rk, logic [7:0] a, logic [5:0] k, logic e);
        tok_res_t r;
        r.rk   = rk;
        r.attr = a;
        r.tk   = k;
        r.line = rk ? line_no : '0;
        r.err  = e;
        r.lst  = 1'b0;
        if (step_buf.size() < MAX_RES)
            step_buf.push_back(r);
    endfunction

    function automatic void tok_end(logic [5:0] k, logic e);
        put_res(RK_END, 8'd0, k, e);
        sc_mode = M_START;
    endfunction

    // Token ends on a char that is then rescanned; the char's newline is undone
    function automatic bit end_rescan(logic [5:0] k, logic e);
        line_no = line_prev;
        tok_end(k, e);
        return 1'b0;
    endfunction

    function automatic void id_add(logic [7:0] c);
        if (id_len < 8)
            id_pref[id_len] = c;
        if (id_len < ID_LEN_TOP)
            id_len++;
        put_res(RK_ATTR, c, K_ID, 1'b0);
    endfunction

    function automatic logic [5:0] id_kind();
        bit hit;
        if (id_len > 8)
            return K_ID;
        for (int i = 0; i < 23; i++)
        begin
            if (kw_txt[i].len() == id_len)
            begin
                hit = 1'b1;
                for (int j = 0; j < id_len; j++)
                    if (kw_txt[i][j] != id_pref[j])
                        hit = 1'b0;
                if (hit)
                    return kw_kind[i];
            end
        end
        return K_ID;
    endfunction

    // One scan pass; returns 0 when the char must be scanned again
    function automatic bit scan_pass(logic [7:0] c, logic eof);
        bit dg, al, ws;
        dg = !eof && c >= "0" && c <= "9";
        al = !eof && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"));
        ws = !eof && (c == " " || (c >= 8'd9 && c <= 8'd13));
        line_prev = line_no;
        if (!eof && c == 8'h0a && line_no != LINE_TOP)
            line_no++;
        case (sc_mode)
            M_START:
            begin
                if (eof) tok_end(K_EOF, 1'b0);
                else if (ws) ;
                else if (al || c == "_")
                begin
                    id_len = '0;
                    id_add(c);
                    sc_mode = M_ID;
                end
                else if (dg && c != "0")
                begin
                    put_res(RK_ATTR, c, K_ID, 1'b0);
                    num_part = NP_INT;
                    sc_mode = M_NUM;
                end
                else
                begin
                    case (c)
                        "0": sc_mode = M_ZERO;
                        "\"": sc_mode = M_STR;
                        "-": sc_mode = M_MINUS;
                        "+": tok_end(K_PLUS, 1'b0);
                        "*": tok_end(K_MUL, 1'b0);
                        "/": tok_end(K_DIV, 1'b0);
                        "^": tok_end(K_POW, 1'b0);
                        "%": tok_end(K_MOD, 1'b0);
                        "(": tok_end(K_LPAREN, 1'b0);
                        ")": tok_end(K_RPAREN, 1'b0);
                        ";": tok_end(K_SEMI, 1'b0);
                        ",": tok_end(K_COMMA, 1'b0);
                        "~": sc_mode = M_TILDE;
                        "<": sc_mode = M_LESS;
                        ">": sc_mode = M_GREATER;
                        "=": sc_mode = M_EQUAL;
                        ".": sc_mode = M_DOT;
                        default: tok_end(K_ID, 1'b1);
                    endcase
                end
                return 1'b1;
            end
            M_ID:
            begin
                if (al || dg || (!eof && c == "_"))
                begin
                    id_add(c);
                    return 1'b1;
                end
                return end_rescan(id_kind(), 1'b0);
            end
            M_NUM:
            begin
                if (dg)
                begin
                    put_res(RK_ATTR, c, K_ID, 1'b0);
                    return 1'b1;
                end
                if (!eof && c == "." && num_part == NP_INT)
                begin
                    put_res(RK_ATTR, c, K_ID, 1'b0);
                    num_part = NP_FRAC;
                    sc_mode = M_AFTER_DOT;
                    return 1'b1;
                end
                if (!eof && (c == "e" || c == "E") && num_part != NP_EXP)
                begin
                    put_res(RK_ATTR, c, K_ID, 1'b0);
                    num_part = NP_EXP;
                    sc_mode = M_AFTER_E;
                    return 1'b1;
                end
                return end_rescan(K_NUMBER, 1'b0);
            end
            M_AFTER_DOT, M_AFTER_SGN:
            begin
                if (dg)
                begin
                    put_res(RK_ATTR, c, K_ID, 1'b0);
                    sc_mode = M_NUM;
                    return 1'b1;
                end
                return end_rescan(K_NUMBER, 1'b1);
            end
            M_AFTER_E:
            begin
                if (!eof && (c == "+" || c == "-"))
                begin
                    put_res(RK_ATTR, c, K_ID, 1'b0);
                    sc_mode = M_AFTER_SGN;
                    return 1'b1;
                end
                if (dg)
                begin
                    put_res(RK_ATTR, c, K_ID, 1'b0);
                    sc_mode = M_NUM;
                    return 1'b1;
                end
                return end_rescan(K_NUMBER, 1'b1);
            end
            M_ZERO:
            begin
                // leading zeros fold away
                if (dg && c == "0")
                    return 1'b1;
                if (dg)
                begin
                    put_res(RK_ATTR, c, K_ID, 1'b0);
                    num_part = NP_INT;
                    sc_mode = M_NUM;
                    return 1'b1;
                end
                if (!eof && (c == "." || c == "e" || c == "E"))
                begin
                    put_res(RK_ATTR, "0", K_ID, 1'b0);
                    put_res(RK_ATTR, c, K_ID, 1'b0);
                    num_part = (c == ".") ? NP_FRAC : NP_EXP;
                    sc_mode = (c == ".") ? M_AFTER_DOT : M_AFTER_E;
                    return 1'b1;
                end
                put_res(RK_ATTR, "0", K_ID, 1'b0);
                return end_rescan(K_NUMBER, 1'b0);
            end
            M_STR:
            begin
                if (eof) tok_end(K_STRING, 1'b1);
                else if (c == "\\") sc_mode = M_ESC;
                else if (c == "\"") tok_end(K_STRING, 1'b0);
                else put_res(RK_ATTR, c, K_ID, 1'b0);
                return 1'b1;
            end
            M_ESC:
            begin
                if (eof)
                begin
                    tok_end(K_STRING, 1'b1);
                    return 1'b1;
                end
                sc_mode = M_STR;
                if (c == "n") put_res(RK_ATTR, 8'd10, K_ID, 1'b0);
                else if (c == "t") put_res(RK_ATTR, 8'd9, K_ID, 1'b0);
                else if (c == "\\" || c == "\"") put_res(RK_ATTR, c, K_ID, 1'b0);
                else if (dg)
                begin
                    esc_val = 10'(c - "0");
                    esc_cnt = 2'd1;
                    sc_mode = M_DEC;
                end
                else tok_end(K_STRING, 1'b1);
                return 1'b1;
            end
            M_DEC:
            begin
                if (dg)
                begin
                    esc_val = 10'(esc_val * 10 + (c - "0"));
                    esc_cnt = esc_cnt + 2'd1;
                    if (esc_cnt == 2'd3 || esc_cnt == 2'd0)
                    begin
                        if (esc_val <= ESC_LIMIT)
                        begin
                            put_res(RK_ATTR, esc_val[7:0], K_ID, 1'b0);
                            sc_mode = M_STR;
                        end
                        else tok_end(K_STRING, 1'b1);
                    end
                    return 1'b1;
                end
                // short escape: char goes back as string text
                put_res(RK_ATTR, esc_val[7:0], K_ID, 1'b0);
                sc_mode = M_STR;
                line_no = line_prev;
                return 1'b0;
            end
            M_MINUS:
            begin
                if (!eof && c == "-")
                begin
                    sc_mode = M_COM1;
                    return 1'b1;
                end
                return end_rescan(K_MINUS, 1'b0);
            end
            M_COM1, M_COM2:
            begin
                if (eof) tok_end(K_EOF, 1'b0);
                else if (c == "[") sc_mode = (sc_mode == M_COM1) ? M_COM2 : M_BLOCK;
                else if (c == 8'h0a) sc_mode = M_START;
                else sc_mode = M_LINE;
                return 1'b1;
            end
            M_LINE:
            begin
                if (eof) tok_end(K_EOF, 1'b0);
                else if (c == 8'h0a) sc_mode = M_START;
                return 1'b1;
            end
            M_BLOCK, M_BLOCK_BR:
            begin
                if (eof) tok_end(K_EOF, 1'b1);
                else if (c == "]") sc_mode = (sc_mode == M_BLOCK) ? M_BLOCK_BR : M_START;
                else sc_mode = M_BLOCK;
                return 1'b1;
            end
            M_TILDE:
            begin
                if (!eof && c == "=")
                begin
                    tok_end(K_NE, 1'b0);
                    return 1'b1;
                end
                return end_rescan(K_NE, 1'b1);
            end
            M_LESS:
            begin
                if (!eof && c == "=")
                begin
                    tok_end(K_LE, 1'b0);
                    return 1'b1;
                end
                return end_rescan(K_LT, 1'b0);
            end
            M_GREATER:
            begin
                if (!eof && c == "=")
                begin
                    tok_end(K_GE, 1'b0);
                    return 1'b1;
                end
                return end_rescan(K_GT, 1'b0);
            end
            M_EQUAL:
            begin
                if (!eof && c == "=")
                begin
                    tok_end(K_EQ, 1'b0);
                    return 1'b1;
                end
                return end_rescan(K_ASSIGN, 1'b0);
            end
            M_DOT:
            begin
                if (!eof && c == ".")
                begin
                    tok_end(K_CONC, 1'b0);
                    return 1'b1;
                end
                return end_rescan(K_CONC, 1'b1);
            end
            default:
            begin
                sc_mode = M_START;
                line_no = line_prev;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void predict_byte(logic [7:0] c, logic eof);
        step_buf.delete();
        for (int p = 0; p < 3; p++)
            if (scan_pass(c, eof))
                break;
        if (step_buf.size() > 0)
            step_buf[step_buf.size() - 1].lst = 1'b1;
        foreach (step_buf[i])
            tok_exp_q.push_back(step_buf[i]);
    endfunction

    // ---------------- stimulus ----------------
    task automatic add_byte(logic [7:0] c, logic eof, bit hold);
        src_req_t r;
        r.ch   = c;
        r.eof  = eof;
        r.hold = hold;
        src_q.push_back(r);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], 1'b0, 1'b0);
    endtask

    string frags[] = '{"do", "else", "end", "false", "function", "if", "local", "nil", "read",
                       "return", "then", "true", "while", "write", "and", "break", "elseif",
                       "for", "in", "not", "or", "repeat", "until", "x_9", "_Zq",
                       "functions", "abcdefghijklmno", "0012", "3.14e-2", "1.e", "7e+",
                       "00.5", "0e5", "0", "9.9.", "1e2e", "\"ab\\n\\t\\\"\\\\\"",
                       "\"\\255\\256\"", "\"\\7z\\12\"", "\"\\q\"", "--c x\n", "--\n",
                       "--[[ a ] b ]]", "--[x\n", "~=", "~", "..", ".", "<=", ">=", "==",
                       "<", ">", "=", "-", "+", "*", "/", "^", "%", "(", ")", ";", ",",
                       " ", "\t", "\n", "@", "$"};

    initial
    begin
        int k;
        // directed: folding, fraction errors, escapes, lone tilde/dot, bad chars
        add_text("007.e9 x\"\\t\\300\"~.");
        add_byte(8'hff, 1'b0, 1'b0);
        add_text("a\n");
        add_byte(8'h00, 1'b1, 1'b0);
        add_byte("\"", 1'b0, 1'b1);
        add_byte(8'h00, 1'b1, 1'b0);
        // random: mostly token fragments, some noise and EOF marks
        while (src_q.size() < 165)
        begin
            k = $urandom_range(0, 99);
            if (src_q.size() > 110 && src_q.size() < 120 && !src_q[$].hold)
                add_byte(" ", 1'b0, 1'b1);
            else if (k < 72)
                add_text(frags[$urandom_range(0, frags.size() - 1)]);
            else if (k < 92)
                add_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            else
                add_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        add_byte(8'h00, 1'b1, 1'b0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (src_q.size() == 0 && !in_valid && tok_exp_q.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && tok_exp_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Idle mix changes every 25 requests: none, sender, receiver, both
    function automatic bit roll_idle(bit sender);
        case ((sent / 25) % 4)
            1: return sender ? ($urandom_range(0, 99) < 45) : 1'b0;
            2: return sender ? 1'b0 : ($urandom_range(0, 99) < 45);
            3: return $urandom_range(0, 99) < 15;
            default: return 1'b0;
        endcase
    endfunction

    // ---------------- driver ----------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= roll_idle(1'b0);
            if (!in_valid || took)
            begin
                if (src_q.size() > 0 && !roll_idle(1'b1) &&
                    (!src_q[0].hold || tok_exp_q.size() == 0))
                begin
                    char_byte    <= src_q[0].ch;
                    end_of_input <= src_q[0].eof;
                    in_valid     <= 1'b1;
                    void'(src_q.pop_front());
                    sent++;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor / checker ----------------
    always @(posedge clk)
    begin
        tok_res_t e;
        took = rst_n && in_valid && !in_stall;
        if (took)
            predict_byte(char_byte, end_of_input);
        if (rst_n && out_valid && !out_stall)
        begin
            if (tok_exp_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result kind=%0d attr=%0h tk=%0d line=%0d",
                         $time, result_kind, attr_byte, token_kind, token_line);
            end
            else
            begin
                e = tok_exp_q.pop_front();
                if (result_kind !== e.rk || attr_byte !== e.attr || token_kind !== e.tk ||
                    token_line !== e.line || lex_error !== e.err || last !== e.lst)
                begin
                    errors++;
                    $display("%0t: mismatch exp rk=%0d attr=%0h tk=%0d line=%0d err=%0d last=%0d",
                             $time, e.rk, e.attr, e.tk, e.line, e.err, e.lst);
                    $display("%0t:          got rk=%0d attr=%0h tk=%0d line=%0d err=%0d last=%0d",
                             $time, result_kind, attr_byte, token_kind, token_line,
                             lex_error, last);
                end
            end
        end
    end

    // Watchdog: cycles with no request or result taken
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIM)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
